// ===== src/fehd_pkg.sv =====
package fehd_pkg;

   localparam int unsigned QueueDepth = 8;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

   localparam logic [31:0] HeaderReset  = 32'hFFFF_AAB1;
   localparam logic [31:0] TrailerReset = 32'hFFFF_CCD1;

   localparam logic [2:0] CountFull = 3'd4;

   // register indexes on the configuration port
   typedef enum logic {
      REG_HEADER  = 1'b0,
      REG_TRAILER = 1'b1
   } reg_index_type;

   // one queued task for the output side: either a whole header burst
   // (four bytes in data) or a single frame byte in data[7:0]
   typedef struct packed {
      logic        is_header;
      logic [31:0] data;
      logic        last;
      logic [31:0] number;
   } entry_type;

endpackage

// ===== src/fehd_front.sv =====
module fehd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic [31:0]         header_word,
   input  logic [31:0]         trailer_word,
   output fehd_pkg::entry_type push_entry,
   output logic                push,
   input  logic                q_full
);

   logic        in_frame_ff, in_frame_in;
   logic [31:0] window_ff, window_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] frames_ff, frames_in;

   logic        accept;
   logic [31:0] window_next;
   logic [2:0]  count_next;
   logic        full;
   logic        hdr_hit;
   logic        trl_hit;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign window_next = {window_ff[23:0], req_data_byte};
   assign count_next  = (count_ff < fehd_pkg::CountFull) ? count_ff + 3'd1 : count_ff;
   assign full        = (count_next == fehd_pkg::CountFull);
   assign hdr_hit     = !in_frame_ff && full && (window_next == header_word);
   assign trl_hit     = in_frame_ff && full && (window_next == trailer_word);

   always_comb begin
      in_frame_in = in_frame_ff;
      window_in   = window_ff;
      count_in    = count_ff;
      frames_in   = frames_ff;
      push        = 1'b0;
      push_entry.is_header = hdr_hit;
      push_entry.data      = hdr_hit ? header_word : {24'd0, req_data_byte};
      push_entry.last      = trl_hit;
      push_entry.number    = trl_hit ? frames_ff + 32'd1 : 32'd0;
      if (accept) begin
         window_in = window_next;
         count_in  = count_next;
         push      = in_frame_ff || hdr_hit;
         if (hdr_hit) begin
            in_frame_in = 1'b1;
            count_in    = 3'd0;
         end else if (trl_hit) begin
            in_frame_in = 1'b0;
            count_in    = 3'd0;
            frames_in   = frames_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         window_ff   <= 32'd0;
         count_ff    <= 3'd0;
         frames_ff   <= 32'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         window_ff   <= window_in;
         count_ff    <= count_in;
         frames_ff   <= frames_in;
      end
   end

endmodule

// ===== src/fehd_queue.sv =====
module fehd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  fehd_pkg::entry_type     push_entry,
   input  logic                    push,
   output logic                    full,
   output fehd_pkg::entry_type     head_entry,
   input  logic                    pop,
   output logic                    empty
);

   localparam int unsigned PtrW = fehd_pkg::QueuePtrW;

   fehd_pkg::entry_type mem_ff [fehd_pkg::QueueDepth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == (PtrW+1)'(fehd_pkg::QueueDepth));
   assign empty      = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + (PtrW+1)'(1);
         2'b01:   count_in = count_ff - (PtrW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/fehd_back.sv =====
module fehd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  fehd_pkg::entry_type     head_entry,
   output logic                    pop,
   input  logic                    empty,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_frame_byte,
   output logic                    rsp_frame_first,
   output logic                    rsp_frame_last,
   output logic [31:0]             rsp_frame_number
);

   logic        valid_ff, valid_in;
   logic [1:0]  sub_ff, sub_in;
   logic [7:0]  byte_ff, byte_in;
   logic        first_ff, first_in;
   logic        last_ff, last_in;
   logic [31:0] number_ff, number_in;

   logic        load;
   logic [7:0]  hdr_byte;

   assign load = !empty && (!valid_ff || !rsp_stall);

   always_comb begin
      unique case (sub_ff)
         2'd0:    hdr_byte = head_entry.data[31:24];
         2'd1:    hdr_byte = head_entry.data[23:16];
         2'd2:    hdr_byte = head_entry.data[15:8];
         default: hdr_byte = head_entry.data[7:0];
      endcase
   end

   always_comb begin
      valid_in  = valid_ff && rsp_stall;
      sub_in    = sub_ff;
      byte_in   = byte_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      number_in = number_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (head_entry.is_header) begin
            byte_in   = hdr_byte;
            first_in  = (sub_ff == 2'd0);
            last_in   = 1'b0;
            number_in = 32'd0;
            sub_in    = sub_ff + 2'd1;
            // pop once the fourth header byte is out
            pop       = (sub_ff == 2'd3);
         end else begin
            byte_in   = head_entry.data[7:0];
            first_in  = 1'b0;
            last_in   = head_entry.last;
            number_in = head_entry.number;
            pop       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      number_ff <= number_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_byte   = byte_ff;
   assign rsp_frame_first  = first_ff;
   assign rsp_frame_last   = last_ff;
   assign rsp_frame_number = number_ff;

endmodule

// ===== src/frame_extractor_header_tail.sv =====
// Header/trailer frame extractor.
// req channel: one raw stream byte per word (req_data_byte), valid/stall.
// rsp channel: frame bytes with first/last marks; frame_number is the
// running frame count on the last trailer byte and zero elsewhere.
// csr port: APB-style, header_word at 0x0, trailer_word at 0x4, pready
// always high; write only while the block is idle.
// A header match turns one input word into four output words; every
// byte inside a frame gives one output word; bytes outside are dropped.
// An accepted frame byte is written into the task queue and then into the
// output register. Throughput: one input word per cycle, one output word
// per cycle; an 8-entry task queue between classifier and output stage
// absorbs header bursts, and req_stall rises only when that queue is full.
// When rsp_stall is high the output word holds and the queue fills up.
// Reset is synchronous: it empties the queue, drops any pending output,
// restores the default header and trailer and clears the frame count.
module frame_extractor_header_tail (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_frame_first,
   output logic        rsp_frame_last,
   output logic [31:0] rsp_frame_number,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0] header_ff, header_in;
   logic [31:0] trailer_ff, trailer_in;
   logic        csr_write;
   fehd_pkg::reg_index_type csr_index;

   fehd_pkg::entry_type     push_entry;
   fehd_pkg::entry_type     head_entry;
   logic                    q_push;
   logic                    q_pop;
   logic                    q_full;
   logic                    q_empty;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = fehd_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      header_in  = header_ff;
      trailer_in = trailer_ff;
      if (csr_write) begin
         unique case (csr_index)
            fehd_pkg::REG_HEADER:  header_in  = csr_pwdata;
            fehd_pkg::REG_TRAILER: trailer_in = csr_pwdata;
            default:               header_in  = header_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         fehd_pkg::REG_HEADER:  csr_prdata = header_ff;
         fehd_pkg::REG_TRAILER: csr_prdata = trailer_ff;
         default:               csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= fehd_pkg::HeaderReset;
         trailer_ff <= fehd_pkg::TrailerReset;
      end else begin
         header_ff  <= header_in;
         trailer_ff <= trailer_in;
      end
   end

   fehd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .header_word   (header_ff),
      .trailer_word  (trailer_ff),
      .push_entry    (push_entry),
      .push          (q_push),
      .q_full        (q_full)
   );

   fehd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push       (q_push),
      .full       (q_full),
      .head_entry (head_entry),
      .pop        (q_pop),
      .empty      (q_empty)
   );

   fehd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_entry       (head_entry),
      .pop              (q_pop),
      .empty            (q_empty),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_first  (rsp_frame_first),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_number (rsp_frame_number)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned DrainCycles = 12;

   typedef struct packed {
      logic [7:0]  value;
      logic        first;
      logic        last;
      logic [31:0] number;
   } frame_word_type;

   // tracks the extractor's state and the frame words still owed by the block
   class frame_tracker_type;
      logic [31:0] header_word;
      logic [31:0] trailer_word;
      bit          in_frame;
      logic [31:0] window;
      int unsigned fill;
      logic [31:0] frames_done;
      frame_word_type words_due[$];
      int unsigned errors;
      int unsigned framed_bytes;

      function new();
         header_word  = fehd_pkg::HeaderReset;
         trailer_word = fehd_pkg::TrailerReset;
         in_frame     = 1'b0;
         window       = '0;
         fill         = 0;
         frames_done  = '0;
         errors       = 0;
         framed_bytes = 0;
      endfunction

      function void set_reg(fehd_pkg::reg_index_type idx, logic [31:0] value);
         if (idx == fehd_pkg::REG_HEADER)
            header_word = value;
         else
            trailer_word = value;
      endfunction

      function logic [31:0] reg_value(fehd_pkg::reg_index_type idx);
         return (idx == fehd_pkg::REG_HEADER) ? header_word : trailer_word;
      endfunction

      function void take_byte(logic [7:0] b);
         window = {window[23:0], b};
         if (fill < 4)
            fill++;
         if (!in_frame) begin
            if (fill == 4 && window == header_word) begin
               for (int k = 3; k >= 0; k--)
                  words_due.insert(words_due.size(),
                                   frame_word_type'{header_word[8*k +: 8], k == 3, 1'b0,
                                                    32'd0});
               in_frame = 1'b1;
               fill = 0;
               framed_bytes++;
            end
         end else begin
            framed_bytes++;
            if (fill == 4 && window == trailer_word) begin
               frames_done = frames_done + 32'd1;
               words_due.insert(words_due.size(),
                                frame_word_type'{b, 1'b0, 1'b1, frames_done});
               in_frame = 1'b0;
               fill = 0;
            end else begin
               words_due.insert(words_due.size(), frame_word_type'{b, 1'b0, 1'b0, 32'd0});
            end
         end
      endfunction

      function void check_word(frame_word_type got);
         frame_word_type want;
         if (words_due.size() == 0) begin
            $error("unexpected word: frame_byte %0h first %0b last %0b number %0h",
                   got.value, got.first, got.last, got.number);
            errors++;
            return;
         end
         want = words_due.pop_front();
         if (got.value !== want.value) begin
            $error("frame_byte: expected %0h, got %0h", want.value, got.value);
            errors++;
         end
         if (got.first !== want.first) begin
            $error("frame_first: expected %0b, got %0b", want.first, got.first);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, got.last);
            errors++;
         end
         if (got.number !== want.number) begin
            $error("frame_number: expected %0h, got %0h", want.number, got.number);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_frame_first;
   logic        rsp_frame_last;
   logic [31:0] rsp_frame_number;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   frame_tracker_type tracker = new();
   bit           idle_on = 1'b1;
   int unsigned  stall_left = 0;
   int unsigned  cycles = 0;

   frame_extractor_header_tail dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_first  (rsp_frame_first),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_number (rsp_frame_number),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: stall in bursts of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && !reset && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_word(frame_word_type'{rsp_frame_byte, rsp_frame_first, rsp_frame_last,
                                             rsp_frame_number});
   end

   // optional write, then read back and compare against the tracked value
   task automatic csr_access(fehd_pkg::reg_index_type idx, bit wr, logic [31:0] value);
      csr_psel  <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      if (wr) begin
         csr_pwrite  <= 1'b1;
         csr_pwdata  <= value;
         csr_penable <= 1'b0;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         tracker.set_reg(idx, value);
      end
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== tracker.reg_value(idx)) begin
         $error("csr_prdata: expected %0h, got %0h", tracker.reg_value(idx), csr_prdata);
         tracker.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_byte(logic [7:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      tracker.take_byte(b);
   endtask

   task automatic send_pattern(logic [31:0] pattern);
      for (int k = 3; k >= 0; k--)
         send_byte(pattern[8*k +: 8]);
   endtask

   // drop valid, let every owed word arrive, then let dropped bytes clear the pipe
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.words_due.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // noise, header, payload, trailer; some sequences break off early
   task automatic send_frame();
      logic [31:0] h;
      logic [31:0] t;
      int unsigned cut;
      h = tracker.header_word;
      t = tracker.trailer_word;
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
      if ($urandom_range(0, 5) == 0) begin
         cut = $urandom_range(1, 3);
         for (int k = 3; k > 3 - int'(cut); k--)
            send_byte(h[8*k +: 8]);
         return;
      end
      send_pattern(h);
      repeat ($urandom_range(0, 8)) begin
         if ($urandom_range(0, 4) == 0)
            send_byte(t[31:24]);
         else
            send_byte(8'($urandom));
      end
      // leave the frame open now and then; the next header then rides as payload
      if ($urandom_range(0, 7) == 0)
         return;
      send_pattern(t);
   endtask

   initial begin
      logic [31:0] hw;
      logic [31:0] tw;
      int unsigned target;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      csr_access(fehd_pkg::REG_HEADER, 1'b0, '0);
      csr_access(fehd_pkg::REG_TRAILER, 1'b0, '0);

      // zero patterns right after reset: the zero window must not match early
      csr_access(fehd_pkg::REG_HEADER, 1'b1, 32'h0000_0000);
      csr_access(fehd_pkg::REG_TRAILER, 1'b1, 32'h0000_0000);
      send_pattern(32'h0000_0000);
      send_pattern(32'h0000_0000);
      wait_drained();

      // default patterns, with overlapping lead-in bytes on header and trailer
      csr_access(fehd_pkg::REG_HEADER, 1'b1, fehd_pkg::HeaderReset);
      csr_access(fehd_pkg::REG_TRAILER, 1'b1, fehd_pkg::TrailerReset);
      send_byte(8'hFF);
      send_pattern(fehd_pkg::HeaderReset);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      send_byte(8'hFF);
      send_pattern(fehd_pkg::TrailerReset);

      target = tracker.framed_bytes;
      for (int p = 0; p < 8; p++) begin
         idle_on = (p != 3) && (p < 6);
         wait_drained();
         case (p)
            1: begin
               hw = 32'hFFFF_FFFF;
               tw = 32'hFFFF_FFFF;
            end
            2: begin
               hw = $urandom;
               tw = hw;
            end
            3: begin
               hw = 32'hABAB_ABAB;
               tw = 32'h0000_0000;
            end
            4: begin
               hw = fehd_pkg::HeaderReset;
               tw = fehd_pkg::TrailerReset;
            end
            5: begin
               hw = 32'h0000_0000;
               tw = 32'hFFFF_FFFF;
            end
            default: begin
               hw = $urandom;
               tw = $urandom;
            end
         endcase
         csr_access(fehd_pkg::REG_HEADER, 1'b1, hw);
         csr_access(fehd_pkg::REG_TRAILER, 1'b1, tw);
         target += 20;
         while (tracker.framed_bytes < target)
            send_frame();
      end

      wait_drained();
      if (tracker.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
src/fehd_pkg.sv
src/fehd_front.sv
src/fehd_queue.sv
src/fehd_back.sv
src/frame_extractor_header_tail.sv
tb/tb.sv
